// ----- sv/arpns_pkg.sv -----
// shared constants, types and helper functions of the arpeggiator note selector
`default_nettype none
package arpns_pkg;
  localparam int MAX_HELD = 16;
  localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CNT_W = $clog2(MAX_HELD + 1);
  localparam int MOD_W = $clog2(2 * MAX_HELD - 1);
  localparam int MAX_RESULTS = 16;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);
  localparam int WORD_W = 32;
  localparam int WCNT_W = $clog2(WORD_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] SEED_FALLBACK = 32'h9E3779B9;
  localparam logic [6:0] DEFAULT_VEL = 7'd100;

  localparam logic [1:0] FUNC_ON = 2'd0;
  localparam logic [1:0] FUNC_OFF = 2'd1;
  localparam logic [1:0] FUNC_STEP = 2'd2;

  localparam logic [2:0] STYLE_PLAYED = 3'd0;
  localparam logic [2:0] STYLE_UP = 3'd1;
  localparam logic [2:0] STYLE_DOWN = 3'd2;
  localparam logic [2:0] STYLE_UPDOWN = 3'd3;
  localparam logic [2:0] STYLE_DOWNUP = 3'd4;
  localparam logic [2:0] STYLE_CONVERGE = 3'd5;
  localparam logic [2:0] STYLE_DIVERGE = 3'd6;
  localparam logic [2:0] STYLE_RANDOM = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_STYLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHORD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_PTR_CLR, OP_PTR_INC, OP_SET_VEL, OP_APPEND, OP_INS_SHIFT,
    OP_INS_PUT, OP_SHIFT_A, OP_SHIFT_O, OP_DEC_CNT, OP_STEP_START, OP_STEP_IDX,
    OP_STEP_BASE, OP_CH_LOAD, OP_SCAN_INC, OP_VEL_HIT, OP_VEL_MISS, OP_EMIT, OP_FLUSH
  } dp_op_t;

  typedef enum logic [1:0] {ASEL_PTR, ASEL_PTR_P1, ASEL_SPTR} asel_t;
  typedef enum logic [1:0] {OSEL_PTR, OSEL_PTR_M1, OSEL_PTR_P1} osel_t;

  typedef struct packed {
    dp_op_t op;
    asel_t  asel;
    osel_t  osel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_on;
    logic is_off;
    logic is_step;
    logic cnt_zero;
    logic cnt_full;
    logic ptr_at_cnt;
    logic ptr_last;
    logic a_match;
    logic o_match;
    logic ins_go;
    logic s_at_cnt;
    logic s_match;
    logic mod_busy;
    logic style_played;
    logic chord;
    logic emit_stall;
    logic flush_stall;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = w;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction
endpackage
`default_nettype wire

// ----- sv/arpns_channels.sv -----
// request, voice and configuration channel interfaces
`default_nettype none
interface arpns_midi_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] note;
  logic [6:0] velocity;
  modport source (output valid, func, note, velocity, input ready);
  modport sink (input valid, func, note, velocity, output ready);
endinterface

interface arpns_voice_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic       last_voice;
  modport source (output valid, out_note, out_velocity, last_voice, input ready);
  modport sink (input valid, out_note, out_velocity, last_voice, output ready);
endinterface

interface arpns_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [arpns_pkg::CFG_IDX_W-1:0] index;
  logic [arpns_pkg::WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/arpeggiator_note_selector_core.sv -----
// top level of the arpeggiator note selector
// usage:
// - midi channel carries one request per item: note on, note off or step boundary
// - voice channel returns the voices of a step, last_voice set on the final one
// - cfg writes style, octave shift, chord mode, generator seed; user writes only while idle, unchecked by the block
// - one request is worked on at a time; midi ready is high only between requests
// - note on/off: the arrival table is scanned for the note, then each table is shifted
//   or inserted into by walks of one entry per cycle
// - step: the 32-bit remainder unit and the index pick, then the velocity lookup; chord
//   mode walks the held set with a lookup per voice
// - voices pass through a staging register and an output register, so a stalled
//   receiver only holds the controller when both are full
// - reset (synchronous, active high) empties the note table, clears the cursor,
//   loads the register defaults and seeds the generator; no clearing pass is needed
`default_nettype none
module arpeggiator_note_selector_core (
  input wire logic      clk,
  input wire logic      rst,
  arpns_midi_if.sink    midi,
  arpns_voice_if.source voice,
  arpns_cfg_if.sink     cfg
);
  arpns_pkg::dp_cmd_t  cmd;
  arpns_pkg::dp_stat_t stat;
  logic                req_ready;

  assign midi.ready = req_ready;

  arpns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (midi.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arpns_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_func     (midi.func),
    .req_note     (midi.note),
    .req_velocity (midi.velocity),
    .cfg          (cfg),
    .voice        (voice)
  );
endmodule
`default_nettype wire

// ----- sv/arpns_mod.sv -----
// iterative restoring remainder unit, one dividend bit per cycle
`default_nettype none
module arpns_mod (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [arpns_pkg::WORD_W-1:0] dividend,
  input  wire logic [arpns_pkg::MOD_W-1:0]  divisor,
  output logic                              busy,
  output logic [arpns_pkg::MOD_W-1:0]       rem
);
  logic [arpns_pkg::WCNT_W-1:0] cnt;
  logic [arpns_pkg::WORD_W-1:0] dvd;
  logic [arpns_pkg::MOD_W-1:0]  div;
  logic [arpns_pkg::MOD_W:0]    trial;
  logic [arpns_pkg::MOD_W:0]    diff;
  logic [arpns_pkg::MOD_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, dvd[arpns_pkg::WORD_W-1]};
    diff = trial - {1'b0, div};
    if (trial >= {1'b0, div}) begin
      rem_next = diff[arpns_pkg::MOD_W-1:0];
    end else begin
      rem_next = trial[arpns_pkg::MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == arpns_pkg::WCNT_W'(arpns_pkg::WORD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= rem_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/arpns_dp.sv -----
// datapath: note tables, pattern cursor, generator, voice staging and output register
`default_nettype none
module arpns_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire arpns_pkg::dp_cmd_t  cmd,
  output arpns_pkg::dp_stat_t      stat,
  input  wire logic [1:0]          req_func,
  input  wire logic [6:0]          req_note,
  input  wire logic [6:0]          req_velocity,
  arpns_cfg_if.sink                cfg,
  arpns_voice_if.source            voice
);
  localparam int W = arpns_pkg::MOD_W + 1;

  logic [2:0]                     style;
  logic [2:0]                     oct_shift;
  logic                           chord_en;
  logic [arpns_pkg::WORD_W-1:0]   random_word;
  logic [arpns_pkg::CNT_W-1:0]    held_count;
  logic [7:0]                     pattern_position;
  logic [6:0]                     arrival_notes [arpns_pkg::MAX_HELD];
  logic [6:0]                     ordered_notes [arpns_pkg::MAX_HELD];
  logic [6:0]                     note_velocities [arpns_pkg::MAX_HELD];
  logic [1:0]                     func_lat;
  logic [6:0]                     note_lat;
  logic [6:0]                     vel_lat;
  logic [arpns_pkg::CNT_W-1:0]    ptr;
  logic [arpns_pkg::CNT_W-1:0]    sptr;
  logic signed [8:0]              delta;
  logic [6:0]                     cand;
  logic                           cand_ok;
  logic [6:0]                     target;
  logic [6:0]                     vvel;
  logic [6:0]                     pend_note;
  logic [6:0]                     pend_vel;
  logic                           pend_valid;
  logic [arpns_pkg::RES_W-1:0]    ecnt;
  logic                           out_valid;

  logic [arpns_pkg::CNT_W-1:0]    a_sel;
  logic [arpns_pkg::CNT_W-1:0]    o_sel;
  logic [arpns_pkg::IDX_W-1:0]    a_addr;
  logic [arpns_pkg::IDX_W-1:0]    o_addr;
  logic [6:0]                     a_rd;
  logic [6:0]                     vel_rd;
  logic [6:0]                     o_rd;
  logic [arpns_pkg::CNT_W:0]      ptr_p1;
  logic [6:0]                     pick_note;
  logic signed [8:0]              s1;
  logic signed [9:0]              oct_semis;
  logic signed [9:0]              s_out;
  logic                           emit_ok;
  logic                           out_free;
  logic                           out_load;
  logic [arpns_pkg::WORD_W-1:0]   rand_next;
  logic [arpns_pkg::WORD_W-1:0]   dividend;
  logic [W-1:0]                   nw;
  logic [W-1:0]                   nm1;
  logic [W-1:0]                   cyc;
  logic                           bounce;
  logic [W-1:0]                   m_sel;
  logic [W-1:0]                   p;
  logic [W-1:0]                   half;
  logic [W-1:0]                   mid;
  logic [W-1:0]                   hi_pick;
  logic [W-1:0]                   idx_calc;
  logic [W-1:0]                   p_inc;
  logic [7:0]                     pos_next;
  logic                           mod_busy;
  logic [arpns_pkg::MOD_W-1:0]    mod_rem;

  arpns_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == arpns_pkg::OP_STEP_START),
    .dividend (dividend),
    .divisor  (m_sel[arpns_pkg::MOD_W-1:0]),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_comb begin
    ptr_p1 = {1'b0, ptr} + 1'b1;
    case (cmd.asel)
      arpns_pkg::ASEL_PTR_P1: a_sel = ptr_p1[arpns_pkg::CNT_W-1:0];
      arpns_pkg::ASEL_SPTR:   a_sel = sptr;
      default:                a_sel = ptr;
    endcase
    case (cmd.osel)
      arpns_pkg::OSEL_PTR_M1: o_sel = ptr - 1'b1;
      arpns_pkg::OSEL_PTR_P1: o_sel = ptr_p1[arpns_pkg::CNT_W-1:0];
      default:                o_sel = ptr;
    endcase
    a_addr = a_sel[arpns_pkg::IDX_W-1:0];
    o_addr = o_sel[arpns_pkg::IDX_W-1:0];
    a_rd = arrival_notes[a_addr];
    vel_rd = note_velocities[a_addr];
    o_rd = ordered_notes[o_addr];
    pick_note = (style == arpns_pkg::STYLE_PLAYED) ? a_rd : o_rd;
    s1 = $signed({2'b00, o_rd}) + delta;
    oct_semis = $signed({{7{oct_shift[2]}}, oct_shift}) * 10'sd12;
    s_out = $signed({3'b000, cand}) + oct_semis;
    emit_ok = cand_ok && !s_out[9] && (s_out[8:7] == 2'b00)
              && (ecnt < arpns_pkg::RES_W'(arpns_pkg::MAX_RESULTS));
    out_free = !out_valid || voice.ready;
    out_load = pend_valid && (((cmd.op == arpns_pkg::OP_EMIT) && emit_ok)
                              || (cmd.op == arpns_pkg::OP_FLUSH));
  end

  always_comb begin
    rand_next = arpns_pkg::xorshift32(random_word);
    dividend = (style == arpns_pkg::STYLE_RANDOM) ? rand_next
               : arpns_pkg::WORD_W'(pattern_position);
    nw = W'(held_count);
    nm1 = nw - 1'b1;
    cyc = (nw << 1) - W'(2);
    bounce = nw > W'(2);
    if (((style == arpns_pkg::STYLE_UPDOWN) || (style == arpns_pkg::STYLE_DOWNUP)) && bounce) begin
      m_sel = cyc;
    end else begin
      m_sel = nw;
    end
    p = W'(mod_rem);
    half = p >> 1;
    mid = nm1 >> 1;
    hi_pick = mid + 1'b1 + half;
    case (style)
      arpns_pkg::STYLE_PLAYED, arpns_pkg::STYLE_UP: idx_calc = p;
      arpns_pkg::STYLE_DOWN: idx_calc = nm1 - p;
      arpns_pkg::STYLE_UPDOWN: idx_calc = (!bounce || (p < nw)) ? p : cyc - p;
      arpns_pkg::STYLE_DOWNUP: idx_calc = (!bounce || (p < nw)) ? nm1 - p : p - nm1;
      arpns_pkg::STYLE_CONVERGE: idx_calc = p[0] ? nm1 - half : half;
      arpns_pkg::STYLE_DIVERGE: begin
        if (p[0]) begin
          idx_calc = (hi_pick > nm1) ? nm1 : hi_pick;
        end else begin
          idx_calc = (half > mid) ? '0 : mid - half;
        end
      end
      default: idx_calc = p;
    endcase
    p_inc = p + 1'b1;
    pos_next = (p_inc == m_sel) ? 8'd0 : 8'(p_inc);
  end

  always_comb begin
    stat.is_on = (func_lat == arpns_pkg::FUNC_ON) && (vel_lat != 7'd0);
    stat.is_off = ((func_lat == arpns_pkg::FUNC_ON) || (func_lat == arpns_pkg::FUNC_OFF))
                  && !stat.is_on;
    stat.is_step = func_lat == arpns_pkg::FUNC_STEP;
    stat.cnt_zero = held_count == '0;
    stat.cnt_full = held_count >= arpns_pkg::CNT_W'(arpns_pkg::MAX_HELD);
    stat.ptr_at_cnt = ptr == held_count;
    stat.ptr_last = ptr_p1 >= {1'b0, held_count};
    stat.a_match = a_rd == note_lat;
    stat.o_match = o_rd == note_lat;
    stat.ins_go = (ptr != '0) && (o_rd > note_lat);
    stat.s_at_cnt = sptr == held_count;
    stat.s_match = a_rd == target;
    stat.mod_busy = mod_busy;
    stat.style_played = style == arpns_pkg::STYLE_PLAYED;
    stat.chord = chord_en;
    stat.emit_stall = emit_ok && pend_valid && !out_free;
    stat.flush_stall = pend_valid && !out_free;
  end

  assign cfg.ready = 1'b1;
  assign voice.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      style <= arpns_pkg::STYLE_UP;
      oct_shift <= 3'd0;
      chord_en <= 1'b0;
      random_word <= arpns_pkg::SEED_FALLBACK;
      held_count <= '0;
      pattern_position <= 8'd0;
      ptr <= '0;
      sptr <= '0;
      pend_valid <= 1'b0;
      ecnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          arpns_pkg::REG_STYLE:  style <= cfg.data[2:0];
          arpns_pkg::REG_OCTAVE: oct_shift <= cfg.data[2:0];
          arpns_pkg::REG_CHORD:  chord_en <= cfg.data[0];
          arpns_pkg::REG_SEED: begin
            random_word <= (cfg.data == '0) ? arpns_pkg::SEED_FALLBACK : cfg.data;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (voice.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        arpns_pkg::OP_LATCH, arpns_pkg::OP_PTR_CLR: ptr <= '0;
        arpns_pkg::OP_PTR_INC, arpns_pkg::OP_SHIFT_A, arpns_pkg::OP_SHIFT_O: begin
          ptr <= ptr + 1'b1;
        end
        arpns_pkg::OP_APPEND: begin
          ptr <= held_count;
          held_count <= held_count + 1'b1;
          if (held_count == '0) begin
            pattern_position <= 8'd0;
          end
        end
        arpns_pkg::OP_INS_SHIFT: ptr <= ptr - 1'b1;
        arpns_pkg::OP_DEC_CNT: held_count <= held_count - 1'b1;
        arpns_pkg::OP_STEP_START: begin
          ecnt <= '0;
          if (style == arpns_pkg::STYLE_RANDOM) begin
            random_word <= rand_next;
            pattern_position <= pattern_position + 1'b1;
          end
        end
        arpns_pkg::OP_STEP_IDX: begin
          ptr <= arpns_pkg::CNT_W'(idx_calc);
          if (style != arpns_pkg::STYLE_RANDOM) begin
            pattern_position <= pos_next;
          end
        end
        arpns_pkg::OP_STEP_BASE: begin
          ptr <= '0;
          sptr <= '0;
        end
        arpns_pkg::OP_CH_LOAD: sptr <= '0;
        arpns_pkg::OP_SCAN_INC: sptr <= sptr + 1'b1;
        arpns_pkg::OP_EMIT: begin
          ptr <= ptr + 1'b1;
          if (emit_ok) begin
            pend_valid <= 1'b1;
            ecnt <= ecnt + 1'b1;
          end
        end
        arpns_pkg::OP_FLUSH: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      arpns_pkg::OP_LATCH: begin
        func_lat <= req_func;
        note_lat <= req_note;
        vel_lat <= req_velocity;
      end
      arpns_pkg::OP_SET_VEL: note_velocities[ptr[arpns_pkg::IDX_W-1:0]] <= vel_lat;
      arpns_pkg::OP_APPEND: begin
        arrival_notes[held_count[arpns_pkg::IDX_W-1:0]] <= note_lat;
        note_velocities[held_count[arpns_pkg::IDX_W-1:0]] <= vel_lat;
      end
      arpns_pkg::OP_INS_SHIFT: ordered_notes[ptr[arpns_pkg::IDX_W-1:0]] <= o_rd;
      arpns_pkg::OP_INS_PUT: ordered_notes[ptr[arpns_pkg::IDX_W-1:0]] <= note_lat;
      arpns_pkg::OP_SHIFT_A: begin
        arrival_notes[ptr[arpns_pkg::IDX_W-1:0]] <= a_rd;
        note_velocities[ptr[arpns_pkg::IDX_W-1:0]] <= vel_rd;
      end
      arpns_pkg::OP_SHIFT_O: ordered_notes[ptr[arpns_pkg::IDX_W-1:0]] <= o_rd;
      arpns_pkg::OP_STEP_BASE: begin
        delta <= $signed({2'b00, pick_note}) - $signed({2'b00, ordered_notes[0]});
        cand <= pick_note;
        cand_ok <= 1'b1;
        target <= pick_note;
        vvel <= vel_rd;
      end
      arpns_pkg::OP_CH_LOAD: begin
        target <= o_rd;
        cand <= s1[6:0];
        cand_ok <= !s1[8] && !s1[7];
      end
      arpns_pkg::OP_VEL_HIT: vvel <= vel_rd;
      arpns_pkg::OP_VEL_MISS: vvel <= arpns_pkg::DEFAULT_VEL;
      arpns_pkg::OP_EMIT: begin
        if (emit_ok) begin
          pend_note <= s_out[6:0];
          pend_vel <= vvel;
          if (pend_valid) begin
            voice.out_note <= pend_note;
            voice.out_velocity <= pend_vel;
            voice.last_voice <= 1'b0;
          end
        end
      end
      arpns_pkg::OP_FLUSH: begin
        if (pend_valid) begin
          voice.out_note <= pend_note;
          voice.out_velocity <= pend_vel;
          voice.last_voice <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= arpns_pkg::CNT_W'(arpns_pkg::MAX_HELD))
    else $error("held count above table size");

  a_voice_cap: assert property (@(posedge clk) disable iff (rst)
    ecnt <= arpns_pkg::RES_W'(arpns_pkg::MAX_RESULTS))
    else $error("too many voices in one step");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == arpns_pkg::OP_APPEND |=> held_count == $past(held_count) + 1'b1)
    else $error("append did not grow the table");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !voice.ready |=> out_valid && $stable(voice.out_note))
    else $error("waiting voice overwritten");
endmodule
`default_nettype wire

// ----- sv/arpns_ctrl.sv -----
// controller state machine sequencing table updates and step voices
`default_nettype none
module arpns_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire arpns_pkg::dp_stat_t stat,
  output arpns_pkg::dp_cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_APPEND, S_INSERT, S_SHIFT_A, S_OSCAN, S_OSHIFT,
    S_STEP_START, S_STEP_WAIT, S_STEP_IDX, S_STEP_BASE, S_CH_LOAD, S_VSCAN, S_EMIT, S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd.op = arpns_pkg::OP_NONE;
    cmd.asel = arpns_pkg::ASEL_PTR;
    cmd.osel = arpns_pkg::OSEL_PTR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = arpns_pkg::OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_on || stat.is_off) begin
          state_next = S_SCAN;
        end else if (stat.is_step && !stat.cnt_zero) begin
          state_next = S_STEP_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.ptr_at_cnt) begin
          state_next = (stat.is_on && !stat.cnt_full) ? S_APPEND : S_IDLE;
        end else if (stat.a_match) begin
          if (stat.is_on) begin
            cmd.op = arpns_pkg::OP_SET_VEL;
            state_next = S_IDLE;
          end else begin
            state_next = S_SHIFT_A;
          end
        end else begin
          cmd.op = arpns_pkg::OP_PTR_INC;
        end
      end
      S_APPEND: begin
        cmd.op = arpns_pkg::OP_APPEND;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.osel = arpns_pkg::OSEL_PTR_M1;
        if (stat.ins_go) begin
          cmd.op = arpns_pkg::OP_INS_SHIFT;
        end else begin
          cmd.op = arpns_pkg::OP_INS_PUT;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_A: begin
        cmd.asel = arpns_pkg::ASEL_PTR_P1;
        if (stat.ptr_last) begin
          cmd.op = arpns_pkg::OP_PTR_CLR;
          state_next = S_OSCAN;
        end else begin
          cmd.op = arpns_pkg::OP_SHIFT_A;
        end
      end
      S_OSCAN: begin
        if (stat.o_match || stat.ptr_last) begin
          state_next = S_OSHIFT;
        end else begin
          cmd.op = arpns_pkg::OP_PTR_INC;
        end
      end
      S_OSHIFT: begin
        cmd.osel = arpns_pkg::OSEL_PTR_P1;
        if (stat.ptr_last) begin
          cmd.op = arpns_pkg::OP_DEC_CNT;
          state_next = S_IDLE;
        end else begin
          cmd.op = arpns_pkg::OP_SHIFT_O;
        end
      end
      S_STEP_START: begin
        cmd.op = arpns_pkg::OP_STEP_START;
        state_next = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (!stat.mod_busy) begin
          state_next = S_STEP_IDX;
        end
      end
      S_STEP_IDX: begin
        cmd.op = arpns_pkg::OP_STEP_IDX;
        state_next = S_STEP_BASE;
      end
      S_STEP_BASE: begin
        cmd.op = arpns_pkg::OP_STEP_BASE;
        if (stat.chord) begin
          state_next = S_CH_LOAD;
        end else if (stat.style_played) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_VSCAN;
        end
      end
      S_CH_LOAD: begin
        if (stat.ptr_at_cnt) begin
          state_next = S_FLUSH;
        end else begin
          cmd.op = arpns_pkg::OP_CH_LOAD;
          state_next = S_VSCAN;
        end
      end
      S_VSCAN: begin
        cmd.asel = arpns_pkg::ASEL_SPTR;
        if (stat.s_at_cnt) begin
          cmd.op = arpns_pkg::OP_VEL_MISS;
          state_next = S_EMIT;
        end else if (stat.s_match) begin
          cmd.op = arpns_pkg::OP_VEL_HIT;
          state_next = S_EMIT;
        end else begin
          cmd.op = arpns_pkg::OP_SCAN_INC;
        end
      end
      S_EMIT: begin
        if (!stat.emit_stall) begin
          cmd.op = arpns_pkg::OP_EMIT;
          state_next = stat.chord ? S_CH_LOAD : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.flush_stall) begin
          cmd.op = arpns_pkg::OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire
